// File: design/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants, codes and controller/datapath bundles of the timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam int OP_W   = 2;
	localparam int DUR_W  = 16;
	localparam int EV_W   = 16;
	localparam int ID_W   = 15;
	localparam int CNT_W  = 6;
	localparam int REM_W  = 17;
	localparam int TICK_W = 10;
	localparam int KIND_W = 2;

	localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(10);
	localparam logic [ID_W-1:0]   ID_WRAP    = ID_W'(32767);

	// opcodes
	localparam logic [OP_W-1:0] OP_SCHED = 2'd0;
	localparam logic [OP_W-1:0] OP_UNSCH = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_SCHED     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UNSCH     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRED   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_TICK_DONE = 2'd3;

	typedef struct packed {
		logic capture;      // take a new word into the item registers
		logic idx_inc;      // move the scan to the next slot
		logic write_sched;  // fill the current slot with the new timer
		logic free_slot;    // release the current slot
		logic write_rem;    // store the decremented remaining time
		logic emit_exp;     // load an expired-event word
		logic emit_final;   // load the closing word of the item
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            slot_free;
		logic            match;
		logic            expire;
		logic            last_idx;
		logic            out_free;
	} dp_stat_t;

endpackage

// File: design/stt_in_if.sv
// ----------------------------------------------------------------------------
// stt_in_if
// Request channel of the timer table: one operation per word.
// ----------------------------------------------------------------------------
interface stt_in_if import stt_pkg::*;;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [DUR_W-1:0] duration_ms;
	logic [EV_W-1:0]  event_code;
	logic [ID_W-1:0]  cancel_id;

	modport source (output valid, output opcode, output duration_ms,
		output event_code, output cancel_id, input ready);
	modport sink (input valid, input opcode, input duration_ms,
		input event_code, input cancel_id, output ready);
endinterface

// File: design/stt_out_if.sv
// ----------------------------------------------------------------------------
// stt_out_if
// Response channel of the timer table: replies, expired events, tick ends.
// ----------------------------------------------------------------------------
interface stt_out_if import stt_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	logic [ID_W-1:0]   timer_id;
	logic [EV_W-1:0]   fired_event;
	logic              table_full;
	logic              found;
	logic [CNT_W-1:0]  active_count;
	logic              last;

	modport source (output valid, output result_kind, output timer_id,
		output fired_event, output table_full, output found,
		output active_count, output last, input ready);
	modport sink (input valid, input result_kind, input timer_id,
		input fired_event, input table_full, input found,
		input active_count, input last, output ready);
endinterface

// File: design/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer: takes a word, scans one slot per cycle unless stalled, closes it.
// ----------------------------------------------------------------------------
module stt_ctrl import stt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic [OP_W-1:0] req_opcode,
	output logic            req_ready,
	input  dp_stat_t        stat,
	output dp_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       advance;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		advance   = 1'b0;
		req_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					if (req_opcode != OP_NOP)
						state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				case (stat.op)
					OP_SCHED: begin
						if (stat.slot_free) begin
							cmd.write_sched = 1'b1;
							state_nxt       = ST_DONE;
						end else
							advance = 1'b1;
					end
					OP_UNSCH: begin
						if (stat.match) begin
							cmd.free_slot = 1'b1;
							state_nxt     = ST_DONE;
						end else
							advance = 1'b1;
					end
					OP_TICK: begin
						if (!stat.slot_free && stat.expire) begin
							// hold the scan until the result register frees
							if (stat.out_free) begin
								cmd.free_slot = 1'b1;
								cmd.emit_exp  = 1'b1;
								advance       = 1'b1;
							end
						end else begin
							cmd.write_rem = !stat.slot_free;
							advance       = 1'b1;
						end
					end
					default: state_nxt = ST_DONE;
				endcase
				if (advance) begin
					if (stat.last_idx)
						state_nxt = ST_DONE;
					else
						cmd.idx_inc = 1'b1;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.emit_final = 1'b1;
					state_nxt      = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	a_final_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_final |=> state_q == ST_IDLE)
		else $error("closing word did not return the sequencer to idle");

	a_scan_only_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && state_nxt == ST_SCAN) |-> cmd.capture)
		else $error("scan started without a captured word");

	a_single_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_exp && cmd.emit_final))
		else $error("two result words loaded in one cycle");

endmodule

// File: design/stt_dp.sv
// ----------------------------------------------------------------------------
// stt_dp
// Slot storage, id and occupancy counters, tick subtractor, result register.
// ----------------------------------------------------------------------------
module stt_dp import stt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_wdata,
	input  logic [OP_W-1:0]   req_opcode,
	input  logic [DUR_W-1:0]  req_duration_ms,
	input  logic [EV_W-1:0]   req_event_code,
	input  logic [ID_W-1:0]   req_cancel_id,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output logic [KIND_W-1:0] rsp_result_kind,
	output logic [ID_W-1:0]   rsp_timer_id,
	output logic [EV_W-1:0]   rsp_fired_event,
	output logic              rsp_table_full,
	output logic              rsp_found,
	output logic [CNT_W-1:0]  rsp_active_count,
	output logic              rsp_last
);

	logic [TICK_W-1:0] tick_len_q;
	logic [ID_W-1:0]   id_ctr_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic              flag_q;      // slot stored (schedule) or timer removed
	logic [OP_W-1:0]   op_q;
	logic [DUR_W-1:0]  dur_q;
	logic [EV_W-1:0]   ev_q;
	logic [ID_W-1:0]   cid_q;

	logic [ID_W-1:0]   slot_id_q [NUM_TIMERS];
	logic [REM_W-1:0]  rem_q     [NUM_TIMERS];
	logic [EV_W-1:0]   slot_ev_q [NUM_TIMERS];

	logic [ID_W-1:0]   cur_id;
	logic [REM_W-1:0]  cur_rem;
	logic [REM_W:0]    diff;
	logic              out_free;

	assign cur_id   = slot_id_q[idx_q];
	assign cur_rem  = rem_q[idx_q];
	// sign-extended remaining time minus the tick; nonpositive means expired
	assign diff     = {cur_rem[REM_W-1], cur_rem} - (REM_W+1)'(tick_len_q);
	assign out_free = !rsp_valid || rsp_ready;

	always_comb begin
		stat.op        = op_q;
		stat.slot_free = (cur_id == '0);
		stat.match     = (cid_q != '0) && (cur_id == cid_q);
		stat.expire    = diff[REM_W] || (diff == '0);
		stat.last_idx  = (idx_q == IDX_W'(NUM_TIMERS - 1));
		stat.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_len_q <= TICK_RESET;
			id_ctr_q   <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			flag_q     <= 1'b0;
			op_q       <= OP_NOP;
			for (int i = 0; i < NUM_TIMERS; i++)
				slot_id_q[i] <= '0;
		end else begin
			if (cfg_we)
				tick_len_q <= cfg_wdata;
			if (cmd.capture) begin
				op_q   <= req_opcode;
				idx_q  <= '0;
				flag_q <= 1'b0;
				if (req_opcode == OP_SCHED && id_ctr_q == ID_WRAP)
					id_ctr_q <= '0;
			end
			if (cmd.idx_inc)
				idx_q <= idx_q + IDX_W'(1);
			if (cmd.write_sched) begin
				slot_id_q[idx_q] <= id_ctr_q + ID_W'(1);
				id_ctr_q         <= id_ctr_q + ID_W'(1);
				count_q          <= count_q + CNT_W'(1);
				flag_q           <= 1'b1;
			end
			if (cmd.free_slot) begin
				slot_id_q[idx_q] <= '0;
				count_q          <= count_q - CNT_W'(1);
				flag_q           <= 1'b1;
			end
		end
	end

	// payload storage, meaningful only while the slot id is nonzero
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dur_q <= req_duration_ms;
			ev_q  <= req_event_code;
			cid_q <= req_cancel_id;
		end
		if (cmd.write_sched) begin
			rem_q[idx_q]     <= REM_W'(dur_q);
			slot_ev_q[idx_q] <= ev_q;
		end
		if (cmd.write_rem)
			rem_q[idx_q] <= diff[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid <= 1'b0;
		else if (cmd.emit_exp || cmd.emit_final)
			rsp_valid <= 1'b1;
		else if (rsp_ready)
			rsp_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_exp) begin
			rsp_result_kind  <= KIND_EXPIRED;
			rsp_timer_id     <= cur_id;
			rsp_fired_event  <= slot_ev_q[idx_q];
			rsp_table_full   <= 1'b0;
			rsp_found        <= 1'b0;
			rsp_active_count <= count_q - CNT_W'(1);
			rsp_last         <= 1'b0;
		end else if (cmd.emit_final) begin
			case (op_q)
				OP_SCHED: rsp_result_kind <= KIND_SCHED;
				OP_UNSCH: rsp_result_kind <= KIND_UNSCH;
				default:  rsp_result_kind <= KIND_TICK_DONE;
			endcase
			rsp_timer_id     <= (op_q == OP_SCHED) ? id_ctr_q : '0;
			rsp_fired_event  <= '0;
			rsp_table_full   <= (op_q == OP_SCHED) && !flag_q;
			rsp_found        <= (op_q == OP_UNSCH) && flag_q;
			rsp_active_count <= count_q;
			rsp_last         <= 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_TIMERS))
		else $error("occupancy count above table size");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_exp || cmd.emit_final) |-> out_free)
		else $error("result word loaded over an untaken word");

	a_sched_fills_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_sched |=> slot_id_q[$past(idx_q)] != '0)
		else $error("scheduled slot left with a zero id");

endmodule

// File: design/software_timer_table_unit.sv
// ----------------------------------------------------------------------------
// software_timer_table_unit
// One-shot timer table: schedule, unschedule and tick over NUM_TIMERS slots.
// ----------------------------------------------------------------------------
// Sequence: a capture in idle, then a scan of the slots (schedule stops at the
//   first free slot, unschedule at the first match), then the closing word.
// Flow: one item at a time; a tick also stalls on each expiring slot while the
//   result register is still held, and the closing word waits for it as well.
// Reset: arst_n clears all slot ids, the id and occupancy counters and the
//   result valid, and loads a tick length of 10; no clearing pass is needed.
// ----------------------------------------------------------------------------
module software_timer_table_unit import stt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,     // tick length write strobe
	input  logic [TICK_W-1:0] cfg_wdata,  // tick length in ms
	stt_in_if.sink            cmd,        // request words
	stt_out_if.source         rsp         // result words
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// Sequencer: idle / slot scan / closing word. It owns the request ready,
	// so a new word is taken only once the previous item has closed, while a
	// closing word may still sit in the result register.
	stt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (cmd.valid),
		.req_opcode (cmd.opcode),
		.req_ready  (cmd.ready),
		.stat       (dp_stat),
		.cmd        (dp_cmd)
	);

	// Datapath: slot arrays indexed by the scan pointer, the tick subtractor
	// and the single result register that drives the response channel.
	stt_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.req_opcode       (cmd.opcode),
		.req_duration_ms  (cmd.duration_ms),
		.req_event_code   (cmd.event_code),
		.req_cancel_id    (cmd.cancel_id),
		.cmd              (dp_cmd),
		.stat             (dp_stat),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp.valid),
		.rsp_result_kind  (rsp.result_kind),
		.rsp_timer_id     (rsp.timer_id),
		.rsp_fired_event  (rsp.fired_event),
		.rsp_table_full   (rsp.table_full),
		.rsp_found        (rsp.found),
		.rsp_active_count (rsp.active_count),
		.rsp_last         (rsp.last)
	);

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the one-shot timer table. A local copy of the slot
// table predicts every result word; a checker compares each accepted word
// field by field against the oldest prediction. Directed cases come first,
// then tick length extremes, random traffic and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top import stt_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = NUM_TIMERS + 4;  // scan plus closing word, with margin

	// receiver ready patterns
	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	// one result word as the checker sees it
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
		logic [EV_W-1:0]   ev;
		logic              full;
		logic              hit;
		logic [CNT_W-1:0]  count;
		logic              last;
	} timer_word_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [TICK_W-1:0] cfg_wdata;

	stt_in_if  cmd_bus ();
	stt_out_if rsp_bus ();

	software_timer_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_bus),
		.rsp       (rsp_bus)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predicted table state. Zero in slot_id marks a free slot; remaining time
	// is signed so that a tick can drive it to zero or below.
	// ------------------------------------------------------------------------
	logic signed [REM_W-1:0] slot_rem [NUM_TIMERS] = '{default: '0};
	logic [EV_W-1:0]         slot_ev  [NUM_TIMERS] = '{default: '0};
	logic [ID_W-1:0]         slot_id  [NUM_TIMERS] = '{default: '0};
	logic [ID_W-1:0]         id_ctr    = '0;
	logic [CNT_W-1:0]        occ_count = '0;
	logic [TICK_W-1:0]       tick_len  = TICK_RESET;

	timer_word_t awaited_words [$];

	// bench bookkeeping
	int err_count     = 0;
	int words_checked = 0;
	int items_sent    = 0;
	int expired_seen  = 0;
	int full_seen     = 0;
	int hits_seen     = 0;
	int cyc_count     = 0;

	// sender burst control and receiver control
	bit       gaps_on     = 1'b0;
	int       burst_left  = 0;
	rx_mode_t rx_mode     = RX_ALWAYS;
	bit       hold_toggle = 1'b0;  // flipped by a test to request a hold-off
	bit       hold_seen   = 1'b0;  // receiver's copy of the last request
	int       hold_left   = 0;
	int       rx_phase    = 0;

	// queue one predicted word; the count field is the occupancy right now
	function automatic void expect_word(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
			logic [EV_W-1:0] ev, logic full, logic hit, logic last);
		timer_word_t w;
		w.kind  = kind;
		w.id    = id;
		w.ev    = ev;
		w.full  = full;
		w.hit   = hit;
		w.count = occ_count;
		w.last  = last;
		awaited_words.push_back(w);
	endfunction

	function automatic void release_slot(int i);
		slot_id[i]  = '0;
		slot_ev[i]  = '0;
		slot_rem[i] = '0;
		if (occ_count != '0)
			occ_count = occ_count - CNT_W'(1);
	endfunction

	// Advance the predicted table by one accepted word and queue its results.
	task automatic apply_timer_op(input logic [OP_W-1:0] op, input logic [DUR_W-1:0] dur,
			input logic [EV_W-1:0] ev, input logic [ID_W-1:0] cid);
		int              hit_idx;
		logic [ID_W-1:0] gone_id;
		logic [EV_W-1:0] gone_ev;
		hit_idx = -1;
		case (op)
			OP_SCHED: begin
				// counter is folded before use, so a full table at the wrap
				// point reports zero
				id_ctr = id_ctr % ID_WRAP;
				for (int i = 0; i < NUM_TIMERS; i++)
					if (hit_idx < 0 && slot_id[i] == '0)
						hit_idx = i;
				if (hit_idx >= 0) begin
					slot_rem[hit_idx] = $signed({1'b0, dur});
					slot_ev[hit_idx]  = ev;
					id_ctr            = id_ctr + ID_W'(1);
					slot_id[hit_idx]  = id_ctr;
					occ_count         = occ_count + CNT_W'(1);
				end
				expect_word(KIND_SCHED, id_ctr, '0, hit_idx < 0, 1'b0, 1'b1);
			end
			OP_UNSCH: begin
				// id zero never matches, free slots never match
				if (cid != '0)
					for (int i = 0; i < NUM_TIMERS; i++)
						if (hit_idx < 0 && slot_id[i] == cid)
							hit_idx = i;
				if (hit_idx >= 0)
					release_slot(hit_idx);
				expect_word(KIND_UNSCH, '0, '0, 1'b0, hit_idx >= 0, 1'b1);
			end
			OP_TICK: begin
				if (occ_count != '0)
					for (int i = 0; i < NUM_TIMERS; i++)
						if (slot_id[i] != '0) begin
							slot_rem[i] = slot_rem[i] -
								$signed({{(REM_W - TICK_W){1'b0}}, tick_len});
							if (slot_rem[i][REM_W-1] || slot_rem[i] == '0) begin
								gone_id = slot_id[i];
								gone_ev = slot_ev[i];
								release_slot(i);
								expect_word(KIND_EXPIRED, gone_id, gone_ev, 1'b0, 1'b0, 1'b0);
							end
						end
				expect_word(KIND_TICK_DONE, '0, '0, 1'b0, 1'b0, 1'b1);
			end
			default: ;  // opcode 3 is dropped by the block
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Sender. Called at a rising edge; returns at the edge where the word was
	// taken. With gaps on, words go out in random bursts separated by idle
	// stretches of random length.
	// ------------------------------------------------------------------------
	task automatic issue(input logic [OP_W-1:0] op, input logic [DUR_W-1:0] dur,
			input logic [EV_W-1:0] ev, input logic [ID_W-1:0] cid);
		if (gaps_on && burst_left == 0) begin
			cmd_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
		if (gaps_on)
			burst_left--;
		cmd_bus.valid       <= 1'b1;
		cmd_bus.opcode      <= op;
		cmd_bus.duration_ms <= dur;
		cmd_bus.event_code  <= ev;
		cmd_bus.cancel_id   <= cid;
		do
			@(posedge clk);
		while (cmd_bus.ready !== 1'b1);
		apply_timer_op(op, dur, ev, cid);
		if (op != OP_NOP)
			items_sent++;
	endtask

	// Stop sending and wait until every predicted word has arrived. The extra
	// cycles cover a dropped opcode-3 word still being worked on.
	task automatic settle();
		cmd_bus.valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Tick length is only changed with the table idle.
	task automatic set_tick_length(input logic [TICK_W-1:0] len);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tick_len  = len;
	endtask

	// ------------------------------------------------------------------------
	// Receiver. Ready follows the current pattern, except during a requested
	// hold-off, which this process counts down on its own.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rx_phase = rx_phase + 1;
		if (arst_n !== 1'b1) begin
			rsp_bus.ready <= 1'b0;
		end else if (hold_toggle != hold_seen) begin
			hold_seen     <= hold_toggle;
			hold_left     <= HOLD_CYCLES;
			rsp_bus.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			rsp_bus.ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS:  rsp_bus.ready <= 1'b1;
				RX_RANDOM:  rsp_bus.ready <= ($urandom_range(0, 3) != 0);
				RX_PATTERN: rsp_bus.ready <= ((rx_phase % 7) >= 2);
				default:    rsp_bus.ready <= 1'b1;
			endcase
		end
	end

	function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, fname, want, got);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Checker: every accepted word is matched against the oldest prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : word_check
		timer_word_t want;
		if (arst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			if (awaited_words.size() == 0) begin
				err_count++;
				$display("%0t ns: stray word, expected none, actual kind %0h id %0h",
					$time, rsp_bus.result_kind, rsp_bus.timer_id);
			end else begin
				want = awaited_words.pop_front();
				words_checked++;
				check_field("result_kind",  32'(want.kind),  32'(rsp_bus.result_kind));
				check_field("timer_id",     32'(want.id),    32'(rsp_bus.timer_id));
				check_field("fired_event",  32'(want.ev),    32'(rsp_bus.fired_event));
				check_field("table_full",   32'(want.full),  32'(rsp_bus.table_full));
				check_field("found",        32'(want.hit),   32'(rsp_bus.found));
				check_field("active_count", 32'(want.count), 32'(rsp_bus.active_count));
				check_field("last",         32'(want.last),  32'(rsp_bus.last));
				if (want.kind == KIND_EXPIRED)
					expired_seen++;
				if (want.full)
					full_seen++;
				if (want.hit)
					hits_seen++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc_count++;
		if (cyc_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still awaited",
				cyc_count, awaited_words.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Directed: empty tick, id zero, zero and max durations, unknown id, a
	// dropped opcode, full table, reuse of a freed slot, exact-zero expiry.
	// ------------------------------------------------------------------------
	task automatic test_directed();
		rx_mode <= RX_ALWAYS;
		gaps_on = 1'b0;
		issue(OP_TICK,  '0, '0, '0);                   // nothing running
		issue(OP_UNSCH, '0, '0, '0);                   // id zero never matches
		issue(OP_SCHED, '0, 16'hFFFF, '0);             // zero duration, id 1
		issue(OP_SCHED, 16'hFFFF, '0, '0);             // longest duration, id 2
		issue(OP_TICK,  '0, '0, '0);                   // zero duration fires now
		issue(OP_UNSCH, '0, '0, 15'h7FFF);             // unknown id
		issue(OP_UNSCH, '0, '0, 15'd2);                // hit
		issue(OP_NOP, 16'hFFFF, 16'hFFFF, 15'h7FFF);   // dropped, no word
		for (int k = 1; k <= NUM_TIMERS; k++)
			issue(OP_SCHED, DUR_W'(10 * k), EV_W'(16'h1000 + k), '0);
		issue(OP_SCHED, 16'd500, 16'hBEEF, '0);        // table full
		issue(OP_UNSCH, '0, '0, 15'd5);                // frees slot 2
		issue(OP_SCHED, 16'd25, 16'hCAFE, '0);         // lands in slot 2
		issue(OP_TICK,  '0, '0, '0);                   // 10 - 10 hits zero exactly
		issue(OP_TICK,  '0, '0, '0);
		settle();
	endtask

	// Tick length extremes, including zero (only zero-remaining timers fire)
	// and the all-ones register value.
	task automatic test_tick_extremes();
		set_tick_length('0);
		issue(OP_SCHED, '0, 16'h1234, '0);
		issue(OP_SCHED, 16'd5, 16'h4321, '0);
		issue(OP_TICK,  '0, '0, '0);
		set_tick_length(TICK_W'(1));
		issue(OP_TICK, '0, '0, '0);
		issue(OP_TICK, '0, '0, '0);
		set_tick_length(TICK_W'(1000));
		issue(OP_SCHED, 16'd1000, 16'h00AA, '0);
		issue(OP_SCHED, 16'd1001, 16'h00BB, '0);
		issue(OP_TICK,  '0, '0, '0);
		issue(OP_TICK,  '0, '0, '0);
		set_tick_length('1);
		issue(OP_SCHED, 16'd1023, 16'h8001, '0);
		issue(OP_TICK,  '0, '0, '0);
		settle();
	endtask

	// ------------------------------------------------------------------------
	// Random traffic in phases, each with its own tick length, receiver
	// pattern and sender burst setting. Durations mostly span a few ticks so
	// that expiries are frequent; some use the full 16-bit range.
	// ------------------------------------------------------------------------
	task automatic test_random_traffic();
		logic [TICK_W-1:0] len;
		logic [OP_W-1:0]   op;
		logic [DUR_W-1:0]  dur;
		logic [ID_W-1:0]   cid;
		logic [ID_W-1:0]   live [$];
		int                counted;
		int                pick;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       len = TICK_W'(1);
				1:       len = TICK_W'(1000);
				2:       len = '0;
				3:       len = '1;
				default: len = TICK_W'($urandom_range(1, 1000));
			endcase
			set_tick_length(len);
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			gaps_on = (phase != 4);  // one phase runs back to back
			counted = 0;
			while (counted < 40) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					op = OP_SCHED;
				else if (pick < 60)
					op = OP_UNSCH;
				else if (pick < 95)
					op = OP_TICK;
				else
					op = OP_NOP;
				if ($urandom_range(0, 7) == 0)
					dur = DUR_W'($urandom_range(0, 65535));
				else
					dur = DUR_W'($urandom_range(0, 4 * len + 1));
				live.delete();
				foreach (slot_id[i])
					if (slot_id[i] != '0)
						live.push_back(slot_id[i]);
				if (live.size() != 0 && $urandom_range(0, 1) == 1)
					cid = live[$urandom_range(0, live.size() - 1)];
				else if ($urandom_range(0, 3) == 0)
					cid = '0;
				else
					cid = ID_W'($urandom_range(0, 32767));
				issue(op, dur, EV_W'($urandom_range(0, 65535)), cid);
				if (op != OP_NOP)
					counted++;
			end
		end
		settle();
	endtask

	// Receiver goes quiet for a long stretch while words keep coming, so the
	// result register backs up into the request channel.
	task automatic test_backpressure();
		settle();
		rx_mode     <= RX_ALWAYS;
		hold_toggle = !hold_toggle;
		gaps_on     = 1'b0;
		for (int k = 0; k < 30; k++)
			issue((k % 3 == 2) ? OP_TICK : OP_SCHED,
				DUR_W'($urandom_range(0, 3 * tick_len)),
				EV_W'($urandom_range(0, 65535)), '0);
		settle();
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		cmd_bus.valid       = 1'b0;
		cmd_bus.opcode      = OP_NOP;
		cmd_bus.duration_ms = '0;
		cmd_bus.event_code  = '0;
		cmd_bus.cancel_id   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_tick_extremes();
		test_random_traffic();
		test_backpressure();
		settle();

		$display("Sent %0d timer operations and checked %0d result words in %0d cycles.",
			items_sent, words_checked, cyc_count);
		$display("Seen: %0d expiries, %0d full-table replies, %0d successful cancels.",
			expired_seen, full_seen, hits_seen);
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
